>>> src/smt_pkg.sv
`default_nettype none

package smt_pkg;

    // Store geometry.
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Beat field widths.
    localparam int KEY_W  = 32;
    localparam int ACT_W  = 2;
    localparam int FCNT_W = 7;

    // Action codes. Any other code only queries.
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ERASE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    // Neighbor values reported when there is no neighbor.
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    // Datapath operations selected by the control word.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
    localparam logic [OP_W-1:0] OP_SCAN    = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_UP  = 3'd2;
    localparam logic [OP_W-1:0] OP_MOVE_UP = 3'd3;
    localparam logic [OP_W-1:0] OP_PUT_KEY = 3'd4;
    localparam logic [OP_W-1:0] OP_SET_DN  = 3'd5;
    localparam logic [OP_W-1:0] OP_MOVE_DN = 3'd6;
    localparam logic [OP_W-1:0] OP_FINISH  = 3'd7;

    // Conditions that keep the sequencer on its current step.
    localparam int HOLD_W = 2;
    localparam logic [HOLD_W-1:0] H_NONE     = 2'd0;
    localparam logic [HOLD_W-1:0] H_NO_BEAT  = 2'd1;
    localparam logic [HOLD_W-1:0] H_BUSY     = 2'd2;
    localparam logic [HOLD_W-1:0] H_OUT_FULL = 2'd3;

    // Conditions that send the sequencer to the step's jump target.
    localparam int J_W = 2;
    localparam logic [J_W-1:0] J_NEVER     = 2'd0;
    localparam logic [J_W-1:0] J_ALWAYS    = 2'd1;
    localparam logic [J_W-1:0] J_NO_INSERT = 2'd2;

    // Program steps.
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [PC_W-1:0] ST_SCAN    = 3'd1;
    localparam logic [PC_W-1:0] ST_SET_UP  = 3'd2;
    localparam logic [PC_W-1:0] ST_MOVE_UP = 3'd3;
    localparam logic [PC_W-1:0] ST_PUT_KEY = 3'd4;
    localparam logic [PC_W-1:0] ST_SET_DN  = 3'd5;
    localparam logic [PC_W-1:0] ST_MOVE_DN = 3'd6;
    localparam logic [PC_W-1:0] ST_FINISH  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [HOLD_W-1:0] hold;
        logic [J_W-1:0]    jump;
        logic [PC_W-1:0]   target;
    } t_uword;

    typedef struct packed {
        logic beat;
        logic busy;
        logic no_insert;
        logic out_full;
    } t_status;

    // The control program. A held step repeats; otherwise a taken jump goes
    // to the target and anything else falls through to the next step.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            ST_IDLE:    w = '{OP_LOAD,    H_NO_BEAT,  J_NEVER,     ST_IDLE};
            ST_SCAN:    w = '{OP_SCAN,    H_BUSY,     J_NEVER,     ST_IDLE};
            ST_SET_UP:  w = '{OP_SET_UP,  H_NONE,     J_NO_INSERT, ST_SET_DN};
            ST_MOVE_UP: w = '{OP_MOVE_UP, H_BUSY,     J_NEVER,     ST_IDLE};
            ST_PUT_KEY: w = '{OP_PUT_KEY, H_NONE,     J_ALWAYS,    ST_FINISH};
            ST_SET_DN:  w = '{OP_SET_DN,  H_NONE,     J_NEVER,     ST_IDLE};
            ST_MOVE_DN: w = '{OP_MOVE_DN, H_BUSY,     J_NEVER,     ST_IDLE};
            ST_FINISH:  w = '{OP_FINISH,  H_OUT_FULL, J_ALWAYS,    ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/smt_if.sv
`default_nettype none

// Request channel: one action and one key per beat.
interface smt_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [smt_pkg::ACT_W-1:0]             action;
    logic signed [smt_pkg::KEY_W-1:0]      key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

// Result channel: one result per request.
interface smt_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  present;
    logic [smt_pkg::FCNT_W-1:0]            count_smaller;
    logic [smt_pkg::FCNT_W-1:0]            count_equal;
    logic [smt_pkg::FCNT_W-1:0]            count_greater;
    logic signed [smt_pkg::KEY_W-1:0]      next_value;
    logic signed [smt_pkg::KEY_W-1:0]      prev_value;
    logic [smt_pkg::FCNT_W-1:0]            entries_after;
    logic                                  rejected;

    modport source (output valid, output present, output count_smaller,
                    output count_equal, output count_greater, output next_value,
                    output prev_value, output entries_after, output rejected,
                    input ready);
    modport sink   (input valid, input present, input count_smaller,
                    input count_equal, input count_greater, input next_value,
                    input prev_value, input entries_after, input rejected,
                    output ready);
endinterface

`default_nettype wire

>>> src/sorted_multiset_table.sv
`default_nettype none

// Channel   Direction  Beat contents
// i_in      in         action, key
// o_out     out        present, count_smaller, count_equal, count_greater,
//                      next_value, prev_value, entries_after, rejected
//
// A request's time from its beat to the next request beat grows with n, the
// entry count before the request, and with m, the number of entries shifted
// (n - count_smaller on an accepted insert, count_greater on an erase that
// hits, zero otherwise); its result is presented in the same cycle in which
// the table is ready again. The time is set by the single read port of the
// key store, which is walked once for the scan and once for the shift.
// Reset is synchronous and active low; it empties the table and clears the
// sequencer, while the key store itself needs no clearing. A result waits in
// the output register while the next request is taken and worked on.

module sorted_multiset_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    smt_in_if.sink     i_in,
    smt_out_if.source  o_out
);
    import smt_pkg::*;

    // The sequencer steps through a small program: it waits for a request,
    // scans the sorted store to gather counts and neighbors, then opens a gap
    // and drops the key in, or closes the run of erased copies, as the action
    // asks, and finally loads the result register. The datapath does what each
    // control word names and reports the conditions the program branches on.
    t_status          status;
    logic [OP_W-1:0]  op;

    smt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_op     (op)
    );

    smt_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_in     (i_in),
        .o_out    (o_out),
        .o_status (status)
    );

endmodule

`default_nettype wire

>>> src/smt_ram.sv
`default_nettype none

module smt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/smt_seq.sv
`default_nettype none

module smt_seq (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire smt_pkg::t_status        i_status,
    output logic [smt_pkg::OP_W-1:0]     o_op
);
    import smt_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w;
    logic            hold_hit;
    logic            jump_hit;

    assign w = ucode(r_pc);

    always_comb begin
        unique case (w.hold)
            H_NONE:     hold_hit = 1'b0;
            H_NO_BEAT:  hold_hit = !i_status.beat;
            H_BUSY:     hold_hit = i_status.busy;
            H_OUT_FULL: hold_hit = i_status.out_full;
        endcase
    end

    always_comb begin
        unique case (w.jump)
            J_ALWAYS:    jump_hit = 1'b1;
            J_NO_INSERT: jump_hit = i_status.no_insert;
            default:     jump_hit = 1'b0;
        endcase
    end

    always_comb begin
        if (hold_hit) begin
            n_pc = r_pc;
        end else if (jump_hit) begin
            n_pc = w.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op = w.op;

endmodule

`default_nettype wire

>>> src/smt_dp.sv
`default_nettype none

module smt_dp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [smt_pkg::OP_W-1:0] i_op,
    smt_in_if.sink                     i_in,
    smt_out_if.source                  o_out,
    output smt_pkg::t_status           o_status
);
    import smt_pkg::*;

    // Request and loop registers.
    logic [ACT_W-1:0]        r_act;
    logic signed [KEY_W-1:0] r_key;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_cnt;
    logic [ADDR_W-1:0]       r_src;
    logic [ADDR_W-1:0]       r_wa;
    logic                    r_pv;

    // Scan results.
    logic [CNT_W-1:0]        r_lo;
    logic [CNT_W-1:0]        r_eq;
    logic [CNT_W-1:0]        r_gt;
    logic signed [KEY_W-1:0] r_prev;
    logic signed [KEY_W-1:0] r_next;

    // Output register.
    logic                    r_ov;
    logic                    r_present;
    logic [FCNT_W-1:0]       r_smaller;
    logic [FCNT_W-1:0]       r_equal;
    logic [FCNT_W-1:0]       r_greater;
    logic signed [KEY_W-1:0] r_onext;
    logic signed [KEY_W-1:0] r_oprev;
    logic [FCNT_W-1:0]       r_after;
    logic                    r_rej;

    logic                    beat;
    logic                    full;
    logic                    ins_ok;
    logic                    out_full;
    logic                    rd_live;
    logic [CNT_W-1:0]        hi;
    logic [CNT_W-1:0]        after;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [KEY_W-1:0]        ram_wdata;
    logic [KEY_W-1:0]        ram_rdata;
    logic signed [KEY_W-1:0] rd_key;

    smt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_src),
        .o_rdata (ram_rdata)
    );

    assign rd_key   = $signed(ram_rdata);
    assign i_in.ready = (i_op == OP_LOAD) && i_rst_n;
    assign beat     = i_in.valid && i_in.ready;
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign ins_ok   = (r_act == ACT_INSERT) && !full;
    assign out_full = r_ov && !o_out.ready;
    assign rd_live  = (r_cnt != '0);
    assign hi       = r_lo + r_eq;

    always_comb begin
        if (ins_ok) begin
            after = r_count + 1'b1;
        end else if (r_act == ACT_ERASE) begin
            after = r_count - r_eq;
        end else begin
            after = r_count;
        end
    end

    // The write port either lands a moved entry or places the new key.
    assign ram_we    = (r_pv && (i_op == OP_MOVE_UP || i_op == OP_MOVE_DN))
                       || (i_op == OP_PUT_KEY);
    assign ram_waddr = (i_op == OP_PUT_KEY) ? r_lo[ADDR_W-1:0] : r_wa;
    assign ram_wdata = (i_op == OP_PUT_KEY) ? r_key : ram_rdata;

    assign o_status.beat      = beat;
    assign o_status.busy      = rd_live || r_pv;
    assign o_status.no_insert = !ins_ok;
    assign o_status.out_full  = out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (i_op)
                OP_LOAD: begin
                    if (beat) begin
                        r_act  <= i_in.action;
                        r_key  <= i_in.key;
                        r_cnt  <= r_count;
                        r_src  <= '0;
                        r_pv   <= 1'b0;
                        r_lo   <= '0;
                        r_eq   <= '0;
                        r_gt   <= '0;
                        r_prev <= KEY_MIN;
                        r_next <= KEY_MAX;
                    end
                end
                OP_SCAN: begin
                    r_pv <= rd_live;
                    if (rd_live) begin
                        r_src <= r_src + 1'b1;
                        r_cnt <= r_cnt - 1'b1;
                    end
                    if (r_pv) begin
                        if (rd_key < r_key) begin
                            r_lo   <= r_lo + 1'b1;
                            r_prev <= rd_key;
                        end else if (rd_key == r_key) begin
                            r_eq <= r_eq + 1'b1;
                        end else begin
                            r_gt <= r_gt + 1'b1;
                            if (r_gt == '0) begin
                                r_next <= rd_key;
                            end
                        end
                    end
                end
                OP_SET_UP: begin
                    r_src <= ADDR_W'(r_count - 1'b1);
                    r_cnt <= ins_ok ? (r_count - r_lo) : '0;
                end
                OP_MOVE_UP: begin
                    r_pv <= rd_live;
                    if (rd_live) begin
                        r_wa  <= r_src + 1'b1;
                        r_src <= r_src - 1'b1;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                OP_PUT_KEY: begin
                    r_pv <= 1'b0;
                end
                OP_SET_DN: begin
                    r_src <= hi[ADDR_W-1:0];
                    r_cnt <= (r_act == ACT_ERASE && r_eq != '0) ? (r_count - hi) : '0;
                end
                OP_MOVE_DN: begin
                    r_pv <= rd_live;
                    if (rd_live) begin
                        r_wa  <= r_src - r_eq[ADDR_W-1:0];
                        r_src <= r_src + 1'b1;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                OP_FINISH: begin
                    if (!out_full) begin
                        r_ov      <= 1'b1;
                        r_present <= (r_eq != '0);
                        r_smaller <= FCNT_W'(r_lo);
                        r_equal   <= FCNT_W'(r_eq);
                        r_greater <= FCNT_W'(r_gt);
                        r_onext   <= r_next;
                        r_oprev   <= r_prev;
                        r_after   <= FCNT_W'(after);
                        r_rej     <= (r_act == ACT_INSERT) && full;
                        r_count   <= after;
                    end
                end
            endcase
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.present       = r_present;
    assign o_out.count_smaller = r_smaller;
    assign o_out.count_equal   = r_equal;
    assign o_out.count_greater = r_greater;
    assign o_out.next_value    = r_onext;
    assign o_out.prev_value    = r_oprev;
    assign o_out.entries_after = r_after;
    assign o_out.rejected      = r_rej;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_pv_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> ($past(i_op) == OP_SCAN || $past(i_op) == OP_MOVE_UP
                  || $past(i_op) == OP_MOVE_DN))
        else $error("pending read without a read loop");

    a_up_is_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_MOVE_UP && rd_live) |-> (r_act == ACT_INSERT && !full))
        else $error("upward shift outside an accepted insert");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_FINISH && !out_full) |=> r_ov)
        else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

>>> test/tb_sorted_multiset_table.sv
`default_nettype none

// Self-checking bench for the sorted multiset table.
//
// A short directed script walks the empty table, both key extremes,
// duplicates, an erase that misses and the spare action code. After that,
// randomized episodes fill the table to capacity and push inserts into the
// full table, drain it back to empty, or mix every action at random.
// Every accepted request beat is run through a local model of the table,
// and each result beat is compared field by field with the oldest outstanding
// prediction. Both channels idle at random, with stretches of no idling between.

module tb_sorted_multiset_table;

    import smt_pkg::*;

    localparam int                 CLK_PERIOD    = 10;
    localparam int                 RESET_CYCLES  = 7;
    localparam int                 RANDOM_ITEMS  = 1630;
    localparam int                 POOL_N        = 16;
    localparam int                 SETTLE_CYCLES = 2 * CAPACITY + 16;
    localparam int                 END_WAIT      = 20000;
    localparam longint             TIMEOUT_TIME  = 64'd25_000_000;
    localparam int                 MAX_PRINTS    = 60;
    // The spare action code behaves as a query.
    localparam logic [ACT_W-1:0]   ACT_SPARE     = 2'd3;

    typedef struct packed {
        logic                     present;
        logic [FCNT_W-1:0]        count_smaller;
        logic [FCNT_W-1:0]        count_equal;
        logic [FCNT_W-1:0]        count_greater;
        logic signed [KEY_W-1:0]  next_value;
        logic signed [KEY_W-1:0]  prev_value;
        logic [FCNT_W-1:0]        entries_after;
        logic                     rejected;
    } t_lookup;

    typedef struct {
        int                       seq;
        logic [ACT_W-1:0]         action;
        logic signed [KEY_W-1:0]  key;
        t_lookup                  res;
    } t_outstanding;

    typedef struct {
        logic [ACT_W-1:0]         action;
        logic signed [KEY_W-1:0]  key;
        bit                       typed;
        t_lookup                  want;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    smt_in_if  in_ch ();
    smt_out_if out_ch ();

    sorted_multiset_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Local copy of the table contents, kept sorted.
    logic signed [KEY_W-1:0] table_keys [CAPACITY];
    int                      table_len;

    t_outstanding            outstanding [$];
    logic signed [KEY_W-1:0] key_pool [POOL_N];
    int                      quiet_left [2];
    int                      mismatch_count;
    int                      beats_sent;
    int                      random_sent;
    int                      results_checked;
    int                      n_insert, n_erase, n_query, n_refused, n_erase_hit;
    int                      n_filled, n_emptied;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_TIME);
        $display("timeout with %0d results outstanding", outstanding.size());
        $display("tb_sorted_multiset_table: errors");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Gap before the next beat on one side: 0 is the sender, 1 the receiver.
    // Mostly short, now and then long, with occasional stretches of none.
    function automatic int pick_gap(input int side);
        int r;
        if (quiet_left[side] > 0) begin
            quiet_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 149) == 0) begin
            quiet_left[side] = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_lookup lookup_of(input logic present, input int smaller,
                                          input int equal, input int greater,
                                          input logic signed [KEY_W-1:0] nxt,
                                          input logic signed [KEY_W-1:0] prv,
                                          input int entries, input logic rej);
        t_lookup r;
        r.present       = present;
        r.count_smaller = FCNT_W'(smaller);
        r.count_equal   = FCNT_W'(equal);
        r.count_greater = FCNT_W'(greater);
        r.next_value    = nxt;
        r.prev_value    = prv;
        r.entries_after = FCNT_W'(entries);
        r.rejected      = rej;
        return r;
    endfunction

    // Looks the key up in the table as it stands, then applies the action.
    function automatic t_lookup apply_to_table(input logic [ACT_W-1:0] act,
                                               input logic signed [KEY_W-1:0] k);
        int                      n, lo, hi, i;
        logic signed [KEY_W-1:0] nxt, prv;
        logic                    rej;
        t_lookup                 r;
        n   = table_len;
        lo  = 0;
        rej = 1'b0;
        while (lo < n && table_keys[lo] < k) lo++;
        hi = lo;
        while (hi < n && table_keys[hi] == k) hi++;
        nxt = (hi < n) ? table_keys[hi] : KEY_MAX;
        prv = (lo > 0) ? table_keys[lo - 1] : KEY_MIN;
        r = lookup_of(hi > lo, lo, hi - lo, n - hi, nxt, prv, 0, 1'b0);

        if (act == ACT_INSERT) begin
            if (n >= CAPACITY) begin
                rej = 1'b1;
            end else begin
                for (i = n; i > lo; i--) table_keys[i] = table_keys[i - 1];
                table_keys[lo] = k;
                n++;
            end
        end else if (act == ACT_ERASE && hi > lo) begin
            // Close the gap left by every copy of the key.
            for (i = hi; i < n; i++) table_keys[lo + (i - hi)] = table_keys[i];
            n -= hi - lo;
        end
        table_len       = n;
        r.entries_after = FCNT_W'(n);
        r.rejected      = rej;
        return r;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int                      r;
        logic signed [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            k = key_pool[$urandom_range(0, POOL_N - 1)];
        end else if (r < 65 && table_len > 0) begin
            k = table_keys[$urandom_range(0, table_len - 1)];
            // Near misses land right beside a stored key.
            if (r >= 55) k = r[0] ? k + 1 : k - 1;
        end else if (r < 72) begin
            case ($urandom_range(0, 3))
                0:       k = KEY_MAX;
                1:       k = KEY_MIN;
                2:       k = '0;
                default: k = '1;
            endcase
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    // Drives one request beat, waits for it to be taken, and records what
    // the table should answer. A typed row supplies its own expectation.
    task automatic send_item(input logic [ACT_W-1:0] act,
                             input logic signed [KEY_W-1:0] k,
                             input bit typed, input t_lookup want);
        int           gap;
        t_lookup      pred;
        t_outstanding e;
        gap = pick_gap(0);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.key    <= k;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);

        pred     = apply_to_table(act, k);
        e.seq    = beats_sent;
        e.action = act;
        e.key    = k;
        e.res    = typed ? want : pred;
        outstanding.push_back(e);
        beats_sent++;

        if (act == ACT_INSERT) begin
            n_insert++;
            if (pred.rejected) n_refused++;
            else if (table_len == CAPACITY) n_filled++;
        end else if (act == ACT_ERASE) begin
            n_erase++;
            if (pred.present) begin
                n_erase_hit++;
                if (table_len == 0) n_emptied++;
            end
        end else begin
            n_query++;
        end
    endtask

    task automatic send_random(input logic [ACT_W-1:0] act,
                               input logic signed [KEY_W-1:0] k);
        send_item(act, k, 1'b0, '0);
        random_sent++;
    endtask

    // Holds the request channel off until every answer is back.
    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        while (outstanding.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic compare_result(input t_outstanding e, input t_lookup got);
        string tag;
        tag = $sformatf("beat %0d act %0d key %0d:", e.seq, e.action, e.key);
        if (got.present !== e.res.present)
            flag_mismatch($sformatf("%s present %0b want %0b", tag,
                                    got.present, e.res.present));
        if (got.count_smaller !== e.res.count_smaller)
            flag_mismatch($sformatf("%s count_smaller %0d want %0d", tag,
                                    got.count_smaller, e.res.count_smaller));
        if (got.count_equal !== e.res.count_equal)
            flag_mismatch($sformatf("%s count_equal %0d want %0d", tag,
                                    got.count_equal, e.res.count_equal));
        if (got.count_greater !== e.res.count_greater)
            flag_mismatch($sformatf("%s count_greater %0d want %0d", tag,
                                    got.count_greater, e.res.count_greater));
        if (got.next_value !== e.res.next_value)
            flag_mismatch($sformatf("%s next_value %0d want %0d", tag,
                                    got.next_value, e.res.next_value));
        if (got.prev_value !== e.res.prev_value)
            flag_mismatch($sformatf("%s prev_value %0d want %0d", tag,
                                    got.prev_value, e.res.prev_value));
        if (got.entries_after !== e.res.entries_after)
            flag_mismatch($sformatf("%s entries_after %0d want %0d", tag,
                                    got.entries_after, e.res.entries_after));
        if (got.rejected !== e.res.rejected)
            flag_mismatch($sformatf("%s rejected %0b want %0b", tag,
                                    got.rejected, e.res.rejected));
    endtask

    // Result side: random back-pressure, one check per accepted beat.
    initial begin
        int      stall;
        t_lookup got;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = pick_gap(1);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            got.present       = out_ch.present;
            got.count_smaller = out_ch.count_smaller;
            got.count_equal   = out_ch.count_equal;
            got.count_greater = out_ch.count_greater;
            got.next_value    = out_ch.next_value;
            got.prev_value    = out_ch.prev_value;
            got.entries_after = out_ch.entries_after;
            got.rejected      = out_ch.rejected;
            if (outstanding.size() == 0) begin
                flag_mismatch("result beat with no request outstanding");
            end else begin
                compare_result(outstanding.pop_front(), got);
            end
            results_checked++;
        end
    end

    // Request side: reset, directed script, randomized episodes, wrap-up.
    initial begin
        t_script_row script [$];
        t_script_row row;
        t_lookup     miss_empty;
        int          episode, r, w, i;

        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.action <= ACT_QUERY;
        in_ch.key    <= '0;
        table_len    = 0;
        quiet_left   = '{0, 0};
        for (i = 0; i < POOL_N; i++) begin
            key_pool[i] = (i < POOL_N / 2) ? $signed($urandom_range(0, 40)) - 20
                                           : $signed($urandom);
        end

        // Anything aimed at an empty table finds nothing on either side.
        miss_empty = lookup_of(1'b0, 0, 0, 0, KEY_MAX, KEY_MIN, 0, 1'b0);
        script.push_back('{ACT_QUERY,  '0,    1'b1, miss_empty});
        script.push_back('{ACT_ERASE,  5,     1'b1, miss_empty});
        script.push_back('{ACT_SPARE,  -1,    1'b1, miss_empty});
        script.push_back('{ACT_INSERT, KEY_MAX, 1'b1,
                           lookup_of(1'b0, 0, 0, 0, KEY_MAX, KEY_MIN, 1, 1'b0)});
        script.push_back('{ACT_INSERT, KEY_MIN, 1'b1,
                           lookup_of(1'b0, 0, 0, 1, KEY_MAX, KEY_MIN, 2, 1'b0)});
        // With only the two extremes stored, each neighbor report comes back
        // as the value that also means "none".
        script.push_back('{ACT_QUERY,  KEY_MAX, 1'b1,
                           lookup_of(1'b1, 1, 1, 0, KEY_MAX, KEY_MIN, 2, 1'b0)});
        script.push_back('{ACT_QUERY,  KEY_MIN, 1'b1,
                           lookup_of(1'b1, 0, 1, 1, KEY_MAX, KEY_MIN, 2, 1'b0)});
        // Duplicates, neighbors and an erase that takes every copy at once.
        script.push_back('{ACT_INSERT, 0,  1'b0, '0});
        script.push_back('{ACT_INSERT, 0,  1'b0, '0});
        script.push_back('{ACT_INSERT, 0,  1'b0, '0});
        script.push_back('{ACT_INSERT, -7, 1'b0, '0});
        script.push_back('{ACT_INSERT, 9,  1'b0, '0});
        script.push_back('{ACT_QUERY,  0,  1'b0, '0});
        script.push_back('{ACT_QUERY,  -1, 1'b0, '0});
        script.push_back('{ACT_QUERY,  1,  1'b0, '0});
        script.push_back('{ACT_ERASE,  0,  1'b0, '0});
        script.push_back('{ACT_ERASE,  0,  1'b0, '0});
        // Alternating bit patterns exercise every key bit both ways.
        script.push_back('{ACT_INSERT, 32'sh5555_5555, 1'b0, '0});
        script.push_back('{ACT_INSERT, 32'shAAAA_AAAA, 1'b0, '0});
        script.push_back('{ACT_ERASE,  KEY_MIN, 1'b0, '0});
        script.push_back('{ACT_SPARE,  9,       1'b0, '0});
        script.push_back('{ACT_ERASE,  KEY_MAX, 1'b0, '0});
        script.push_back('{ACT_QUERY,  32'sh5555_5555, 1'b0, '0});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[j]) begin
            row = script[j];
            send_item(row.action, row.key, row.typed, row.want);
        end
        wait_all_results();

        // Episodes rotate through filling, draining and a free mix.
        episode = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (episode % 3)
                0: begin
                    while (table_len < CAPACITY) begin
                        r = $urandom_range(0, 99);
                        if (r < 70)      send_random(ACT_INSERT, pick_key());
                        else if (r < 85) send_random(ACT_QUERY, pick_key());
                        else if (r < 95) send_random(ACT_ERASE, pick_key());
                        else             send_random(ACT_SPARE, pick_key());
                    end
                    // The table is full: further inserts must bounce.
                    repeat ($urandom_range(2, 8)) begin
                        send_random(($urandom_range(0, 2) != 0) ? ACT_INSERT
                                                                : ACT_QUERY,
                                    pick_key());
                    end
                end
                1: begin
                    wait_all_results();
                    while (table_len > 0) begin
                        r = $urandom_range(0, 99);
                        if (r < 70) begin
                            send_random(ACT_ERASE,
                                        table_keys[$urandom_range(0, table_len - 1)]);
                        end else if (r < 85) begin
                            send_random(ACT_QUERY, pick_key());
                        end else if (r < 93) begin
                            send_random(ACT_INSERT, pick_key());
                        end else begin
                            send_random(ACT_ERASE, pick_key());
                        end
                    end
                    repeat ($urandom_range(1, 4)) begin
                        send_random(logic'($urandom_range(0, 3)) ? ACT_QUERY
                                                                 : ACT_ERASE,
                                    pick_key());
                    end
                end
                default: begin
                    repeat ($urandom_range(30, 80)) begin
                        r = $urandom_range(0, 99);
                        if (r < 35)      send_random(ACT_INSERT, pick_key());
                        else if (r < 60) send_random(ACT_ERASE, pick_key());
                        else if (r < 92) send_random(ACT_QUERY, pick_key());
                        else             send_random(ACT_SPARE, pick_key());
                    end
                end
            endcase
            episode++;
        end

        in_ch.valid <= 1'b0;
        for (w = 0; w < END_WAIT && outstanding.size() != 0; w++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (outstanding.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", outstanding.size()));
        end

        $display("run: %0d inserts (%0d refused while full), %0d erases (%0d hits), %0d queries",
                 n_insert, n_refused, n_erase, n_erase_hit, n_query);
        $display("run: table filled %0d times, emptied %0d times, %0d results checked",
                 n_filled, n_emptied, results_checked);
        if (mismatch_count == 0) begin
            $display("tb_sorted_multiset_table: clean");
        end else begin
            $display("tb_sorted_multiset_table: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
